FILE: src/ptw_pkg.sv
// Shared constants, types and helpers for the page table walker.
// Used by the controller, the datapath and the top level; depends on nothing.
package ptw_pkg;

  // Field widths of the request and result channels.
  localparam int VA_W       = 48;
  localparam int FRAME_IN_W = 40;
  localparam int PA_W       = 52;
  localparam int STATUS_W   = 2;

  // Page table geometry.
  localparam int NUM_TABLES        = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int FRAME_BITS        = 40;
  localparam int PAGE_SHIFT        = 12;
  localparam int SLICE_BITS        = 9;

  localparam int TBL_IDX_W   = $clog2(NUM_TABLES);
  localparam int TBL_CNT_W   = $clog2(NUM_TABLES + 1);
  localparam int ADDR_W      = TBL_IDX_W + SLICE_BITS;
  localparam int STORE_DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;
  localparam int FRAME_W     = (FRAME_BITS < FRAME_IN_W) ? FRAME_BITS : FRAME_IN_W;
  localparam int PAY_W       = (FRAME_W > TBL_IDX_W) ? FRAME_W : TBL_IDX_W;
  localparam int ENTRY_W     = PAY_W + 1;
  localparam int PA_FRAME_W  = PA_W - PAGE_SHIFT;
  localparam int LVL_W       = 2;

  localparam logic [LVL_W-1:0] LVL_TOP  = 2'd3;
  localparam logic [LVL_W-1:0] LVL_LEAF = 2'd0;

  // Request kinds.
  localparam logic REQ_MAP       = 1'b0;
  localparam logic REQ_TRANSLATE = 1'b1;

  // Result status codes.
  typedef logic [STATUS_W-1:0] ptw_status_t;
  localparam ptw_status_t ST_OK       = 2'd0;
  localparam ptw_status_t ST_FAULT    = 2'd1;
  localparam ptw_status_t ST_NO_SPACE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load_req;   // capture an accepted request, start at the top level
    logic        clr_step;   // clear one store entry during the reset sweep
    logic        rd_issue;   // read the entry for the current table and level
    logic        step_down;  // follow a present upper-level entry
    logic        alloc;      // take a new table and link it in the current entry
    logic        write_leaf; // write the frame into the last-level entry
    logic        set_res;    // latch the result of the walk
    ptw_status_t res_code;
    logic        load_out;   // move the latched result into the output register
  } ptw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_translate;
    logic level_zero;
    logic entry_present;
    logic tables_full;
  } ptw_sts_t;

  // Nine-bit index of the entry that a virtual address selects at one level.
  function automatic logic [SLICE_BITS-1:0] slice_of(input logic [VA_W-1:0] va,
                                                      input logic [LVL_W-1:0] lvl);
    logic [SLICE_BITS-1:0] s;
    case (lvl)
      2'd3:    s = va[PAGE_SHIFT + 3*SLICE_BITS +: SLICE_BITS];
      2'd2:    s = va[PAGE_SHIFT + 2*SLICE_BITS +: SLICE_BITS];
      2'd1:    s = va[PAGE_SHIFT + SLICE_BITS +: SLICE_BITS];
      default: s = va[PAGE_SHIFT +: SLICE_BITS];
    endcase
    return s;
  endfunction

endpackage

FILE: src/ptw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used by the walker datapath for the page table store.
module ptw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/ptw_ctrl.sv
// Walk sequencer for the page table walker: clearing sweep, level steps, result hand-off.
// Depends on ptw_pkg for command and status types.
module ptw_ctrl
  import ptw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ptw_sts_t sts,
  output ptw_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_WRITE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.res_code  = ST_OK;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_CHECK: begin
        if (sts.is_translate) begin
          // Translate: a missing entry at any level is a fault.
          if (!sts.entry_present) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_FAULT;
            state_nxt    = S_DONE;
          end else if (sts.level_zero) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_OK;
            state_nxt    = S_DONE;
          end else begin
            cmd.step_down = 1'b1;
            state_nxt     = S_LOOKUP;
          end
        end else begin
          // Map: follow or allocate at the upper levels, then write the leaf.
          if (sts.level_zero) begin
            state_nxt = S_WRITE;
          end else if (!sts.entry_present && sts.tables_full) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_NO_SPACE;
            state_nxt    = S_DONE;
          end else begin
            cmd.step_down = sts.entry_present;
            cmd.alloc     = !sts.entry_present;
            state_nxt     = S_LOOKUP;
          end
        end
      end
      S_WRITE: begin
        cmd.write_leaf = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_code   = ST_OK;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A table is only taken while one is left.
  a_alloc_has_space: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> !sts.tables_full)
    else $error("table allocated with the pool exhausted");

  // Entry data is checked only in the cycle after its read was issued.
  a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> ($past(state_r) == S_LOOKUP))
    else $error("entry checked without a preceding read");

  // A new result never overwrites one still waiting at the output.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  // Leaf writes belong to map requests that reached the last level.
  a_leaf_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> (sts.level_zero && !sts.is_translate))
    else $error("leaf write outside the last level of a map");
`endif

endmodule

FILE: src/ptw_dpath.sv
// Datapath of the page table walker: request registers, table store, allocator, result.
// Depends on ptw_pkg and instantiates ptw_ram.
module ptw_dpath
  import ptw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_req_type,
  input  logic [VA_W-1:0]       in_virt_addr,
  input  logic [FRAME_IN_W-1:0] in_frame_number,
  output logic [PA_W-1:0]       out_phys_addr,
  output logic [STATUS_W-1:0]   out_status,
  input  ptw_cmd_t              cmd,
  output ptw_sts_t              sts
);

  logic                 req_type_r;
  logic [VA_W-1:0]      va_r;
  logic [FRAME_W-1:0]   frame_r;
  logic [LVL_W-1:0]     level_r;
  logic [TBL_IDX_W-1:0] table_r;
  logic [TBL_CNT_W-1:0] tables_used_r;
  logic [ADDR_W-1:0]    clr_cnt_r;
  logic [PA_W-1:0]      res_phys_r;
  ptw_status_t          res_status_r;
  logic [PA_W-1:0]      out_phys_r;
  ptw_status_t          out_status_r;

  logic [ADDR_W-1:0]    cur_addr;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0]   wr_data;
  logic [ENTRY_W-1:0]   rd_data;
  logic [PA_W-1:0]      res_phys_nxt;

  // Entry address: table number above the nine-bit slice of this level.
  assign cur_addr = {table_r, slice_of(va_r, level_r)};

  // Store write port: clearing sweep, table link or leaf frame.
  always_comb begin
    wr_en   = cmd.clr_step || cmd.alloc || cmd.write_leaf;
    wr_addr = cmd.clr_step ? clr_cnt_r : cur_addr;
    if (cmd.clr_step) begin
      wr_data = '0;
    end else if (cmd.alloc) begin
      wr_data = {1'b1, PAY_W'(tables_used_r[TBL_IDX_W-1:0])};
    end else begin
      wr_data = {1'b1, PAY_W'(frame_r)};
    end
  end

  ptw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_issue),
    .rd_addr (cur_addr),
    .rd_data (rd_data)
  );

  // Status back to the controller.
  assign sts.clr_last      = (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1));
  assign sts.is_translate  = (req_type_r == REQ_TRANSLATE);
  assign sts.level_zero    = (level_r == LVL_LEAF);
  assign sts.entry_present = rd_data[PAY_W];
  assign sts.tables_full   = (tables_used_r == TBL_CNT_W'(NUM_TABLES));

  // Translated address only for a successful translate.
  always_comb begin
    if (cmd.res_code == ST_OK && req_type_r == REQ_TRANSLATE) begin
      res_phys_nxt = {PA_FRAME_W'(rd_data[FRAME_W-1:0]), va_r[PAGE_SHIFT-1:0]};
    end else begin
      res_phys_nxt = '0;
    end
  end

  // Control counters: allocator and clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tables_used_r <= TBL_CNT_W'(1);
      clr_cnt_r     <= '0;
    end else begin
      if (cmd.alloc) begin
        tables_used_r <= tables_used_r + TBL_CNT_W'(1);
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
    end
  end

  // Request capture and walk position.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type_r <= in_req_type;
      va_r       <= in_virt_addr;
      frame_r    <= in_frame_number[FRAME_W-1:0];
      level_r    <= LVL_TOP;
      table_r    <= '0;
    end else if (cmd.step_down) begin
      level_r <= level_r - LVL_W'(1);
      table_r <= rd_data[TBL_IDX_W-1:0];
    end else if (cmd.alloc) begin
      level_r <= level_r - LVL_W'(1);
      table_r <= tables_used_r[TBL_IDX_W-1:0];
    end
  end

  // Result latch and output register.
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_phys_r   <= res_phys_nxt;
      res_status_r <= cmd.res_code;
    end
    if (cmd.load_out) begin
      out_phys_r   <= res_phys_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_phys_addr = out_phys_r;
  assign out_status    = out_status_r;

endmodule

FILE: src/page_table_walker_core.sv
// Four-level page table walker over an on-chip table store.
// Request channel: in_valid/in_ready with in_req_type (0 map, 1 translate),
//   in_virt_addr (48 bits, bits 47..12 pick the entries) and in_frame_number.
// Result channel: out_valid/out_ready with out_phys_addr and out_status
//   (0 ok, 1 page fault, 2 map out of tables); one result per request.
// After reset the walker sweeps the store once to clear every present bit,
//   one entry per cycle over all NUM_TABLES*512 entries (32768), with in_ready low.
// Each level takes a read (S_LOOKUP) and a check (S_CHECK) on the single store read port.
//   A request is accepted in S_IDLE and handed off from S_DONE. A translate stops
//   at the first missing entry or at the leaf; a full map reads all four levels, then
//   writes the leaf (S_WRITE). New tables come from a bump counter, never freed.
// A result waits in an output register; the next request is accepted while
//   it waits, and its walk runs, but its own result is held back until the
//   receiver takes the earlier one.
// Depends on ptw_pkg, ptw_ctrl, ptw_dpath and ptw_ram.
module page_table_walker_core
  import ptw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [VA_W-1:0]       in_virt_addr,
  input  logic [FRAME_IN_W-1:0] in_frame_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PA_W-1:0]       out_phys_addr,
  output logic [STATUS_W-1:0]   out_status
);

  ptw_cmd_t cmd;
  ptw_sts_t sts;

  ptw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptw_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_req_type     (in_req_type),
    .in_virt_addr    (in_virt_addr),
    .in_frame_number (in_frame_number),
    .out_phys_addr   (out_phys_addr),
    .out_status      (out_status),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

FILE: sim/page_walk_monitor.sv
// Watches the request and result channels of the page table walker, predicts every walk
// and compares each result with the oldest prediction still outstanding.
// Depends on ptw_pkg for field widths, table geometry, request kinds and status codes.
module page_walk_monitor
  import ptw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [VA_W-1:0]       in_virt_addr,
  input  logic [FRAME_IN_W-1:0] in_frame_number,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [PA_W-1:0]       out_phys_addr,
  input  logic [STATUS_W-1:0]   out_status,
  output int                    fail_count,
  output int                    outstanding,
  output int                    ok_seen,
  output int                    fault_seen,
  output int                    full_seen
);

  typedef struct packed {
    logic [PA_W-1:0] phys;
    ptw_status_t     status;
  } walk_result_t;

  // Shadow copy of the table store and of the table allocator.
  bit                    shadow_present [STORE_DEPTH];
  logic [FRAME_IN_W-1:0] shadow_payload [STORE_DEPTH];
  int unsigned           tables_taken;

  walk_result_t pending_walks[$];
  walk_result_t oldest;
  int           mismatches;
  int           n_ok;
  int           n_fault;
  int           n_full;

  // Walks the shadow tables for one request, updating them for a map.
  function automatic walk_result_t walk_tables(input logic kind,
                                               input logic [VA_W-1:0] va,
                                               input logic [FRAME_IN_W-1:0] frame);
    walk_result_t res;
    int unsigned  tbl;
    int unsigned  idx;
    logic [SLICE_BITS-1:0] sl;
    int           lvl;
    bit           stop;
    res.phys   = '0;
    res.status = ST_OK;
    tbl        = 0;
    stop       = 1'b0;
    // Upper levels: follow present entries, allocate missing ones on a map.
    for (lvl = 3; lvl > 0 && !stop; lvl--) begin
      sl  = va[PAGE_SHIFT + SLICE_BITS*lvl +: SLICE_BITS];
      idx = tbl * ENTRIES_PER_TABLE + sl;
      if (!shadow_present[idx]) begin
        if (kind == REQ_TRANSLATE) begin
          res.status = ST_FAULT;
          stop       = 1'b1;
        end else if (tables_taken >= NUM_TABLES) begin
          res.status = ST_NO_SPACE;
          stop       = 1'b1;
        end else begin
          shadow_present[idx] = 1'b1;
          shadow_payload[idx] = FRAME_IN_W'(tables_taken);
          tables_taken++;
        end
      end
      if (!stop) tbl = shadow_payload[idx] % NUM_TABLES;
    end
    // Last level: store the frame, or look it up.
    if (!stop) begin
      sl  = va[PAGE_SHIFT +: SLICE_BITS];
      idx = tbl * ENTRIES_PER_TABLE + sl;
      if (kind == REQ_MAP) begin
        shadow_present[idx] = 1'b1;
        shadow_payload[idx] = frame;
      end else if (!shadow_present[idx]) begin
        res.status = ST_FAULT;
      end else begin
        res.phys = {shadow_payload[idx], va[PAGE_SHIFT-1:0]};
      end
    end
    return res;
  endfunction

  // Counts a mismatch and prints the first ten of them.
  task automatic flag(input string what, input logic [63:0] want_v, input logic [63:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want_v, got_v);
  endtask

  // Predict on each accepted request, compare on each accepted result.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (shadow_present[k]) shadow_present[k] = 1'b0;
      tables_taken = 1;
      pending_walks.delete();
      mismatches = 0;
      n_ok       = 0;
      n_fault    = 0;
      n_full     = 0;
    end else begin
      if (in_valid && in_ready)
        pending_walks.insert(pending_walks.size(),
                             walk_tables(in_req_type, in_virt_addr, in_frame_number));
      if (out_valid && out_ready) begin
        if (out_status == ST_OK) n_ok++;
        else if (out_status == ST_FAULT) n_fault++;
        else if (out_status == ST_NO_SPACE) n_full++;
        if (pending_walks.size() == 0) begin
          flag("unrequested result status", '0, 64'(out_status));
        end else begin
          oldest = pending_walks.pop_front();
          if (out_phys_addr !== oldest.phys)
            flag("phys_addr", 64'(oldest.phys), 64'(out_phys_addr));
          if (out_status !== oldest.status)
            flag("status", 64'(oldest.status), 64'(out_status));
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= pending_walks.size();
    ok_seen     <= n_ok;
    fault_seen  <= n_fault;
    full_seen   <= n_full;
  end

endmodule

FILE: sim/page_table_walker_core_test.sv
// Stimulus and verdict for the page table walker: directed maps and translates, then
// random walks over shared prefixes with random idling. Depends on ptw_pkg, the RTL
// and page_walk_monitor, which does all prediction and checking.
module page_table_walker_core_test;
  import ptw_pkg::*;

  localparam int RANDOM_REQS = 530;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 600000;

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_req_type     = REQ_MAP;
  logic [VA_W-1:0]       in_virt_addr    = '0;
  logic [FRAME_IN_W-1:0] in_frame_number = '0;
  logic                  out_ready       = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic [PA_W-1:0]       out_phys_addr;
  logic [STATUS_W-1:0]   out_status;

  int fail_count;
  int outstanding;
  int ok_seen;
  int fault_seen;
  int full_seen;

  bit want_hold = 1'b0;
  bit no_idle   = 1'b0;
  int cycle_count = 0;
  int maps_sent   = 0;
  int xlats_sent  = 0;
  logic [VA_W-1:0] mapped_pages[$];

  page_table_walker_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_virt_addr    (in_virt_addr),
    .in_frame_number (in_frame_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_phys_addr   (out_phys_addr),
    .out_status      (out_status)
  );

  page_walk_monitor u_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_virt_addr    (in_virt_addr),
    .in_frame_number (in_frame_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_phys_addr   (out_phys_addr),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .ok_seen         (ok_seen),
    .fault_seen      (fault_seen),
    .full_seen       (full_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog; the limit covers the store clear after reset several times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Address near an earlier mapped page, so that walks share tables; sometimes fresh.
  function automatic logic [VA_W-1:0] pick_addr();
    logic [VA_W-1:0] fresh;
    logic [VA_W-1:0] base;
    int k;
    fresh = VA_W'({$urandom(), $urandom()});
    if (mapped_pages.size() == 0 || $urandom_range(0, 99) < 12) return fresh;
    base = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
    k = $urandom_range(0, 9);
    if (k < 5) return {base[VA_W-1:12], fresh[11:0]};
    if (k < 7) return {base[VA_W-1:21], fresh[20:0]};
    if (k < 8) return {base[VA_W-1:30], fresh[29:0]};
    if (k < 9) return {base[VA_W-1:39], fresh[38:0]};
    return fresh;
  endfunction

  function automatic logic [FRAME_IN_W-1:0] pick_frame();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return FRAME_IN_W'({$urandom(), $urandom()});
  endfunction

  // Offers one request, waits for it to be taken, then idles at random.
  task automatic put_request(input logic kind, input logic [VA_W-1:0] va,
                             input logic [FRAME_IN_W-1:0] frame);
    int gap;
    in_valid        <= 1'b1;
    in_req_type     <= kind;
    in_virt_addr    <= va;
    in_frame_number <= frame;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == REQ_MAP) begin
      maps_sent++;
      mapped_pages.insert(mapped_pages.size(), va);
      if (mapped_pages.size() > 48) void'(mapped_pages.pop_front());
    end else begin
      xlats_sent++;
    end
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering until every outstanding request has returned its result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Result side: random stalls, one long hold-off on request, quiet stretches.
  initial begin
    int stall;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (want_hold && !hold_done) begin
        hold_done = 1'b1;
        stall = LONG_HOLD;
      end else if (no_idle) begin
        stall = 0;
      end else begin
        stall = idle_len();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (!no_idle) repeat ($urandom_range(0, 5)) @(posedge clk);
    end
  end

  // Request side.
  initial begin
    int i;
    logic kind;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, extreme addresses and frames, misses at levels 3, 2 and 0, remaps.
    put_request(REQ_TRANSLATE, '0, '0);
    put_request(REQ_MAP, '0, '0);
    put_request(REQ_TRANSLATE, '0, '1);
    put_request(REQ_TRANSLATE, 48'h0000_0000_0FFF, '0);
    put_request(REQ_TRANSLATE, 48'h0000_0000_1000, '0);
    put_request(REQ_TRANSLATE, 48'h0000_4000_0000, '0);
    put_request(REQ_TRANSLATE, 48'h0080_0000_0000, '0);
    put_request(REQ_MAP, '1, '1);
    put_request(REQ_TRANSLATE, '1, '0);
    put_request(REQ_MAP, 48'hAAAA_AAAA_AAAA, 40'h55_5555_5555);
    put_request(REQ_MAP, 48'h5555_5555_5555, 40'hAA_AAAA_AAAA);
    put_request(REQ_TRANSLATE, 48'hAAAA_AAAA_AAAA, '0);
    put_request(REQ_TRANSLATE, 48'h5555_5555_5555, '0);
    put_request(REQ_MAP, '0, 40'h00_0001_2345);
    put_request(REQ_TRANSLATE, 48'h0000_0000_0123, '0);
    put_request(REQ_MAP, 48'h0000_0000_1000, 40'h80_0000_0001);
    put_request(REQ_TRANSLATE, 48'h0000_0000_1ABC, '0);
    put_request(REQ_MAP, 48'h0000_001F_F000, 40'h7F_FFFF_FFFF);
    put_request(REQ_TRANSLATE, 48'h0000_001F_FFFF, '0);

    // Random: mostly walks over shared prefixes, until the tables run out and beyond.
    for (i = 0; i < RANDOM_REQS; i++) begin
      if (i == 150) want_hold <= 1'b1;
      if (i == 250) wait_drained();
      if (i == 330) no_idle <= 1'b1;
      if (i == 400) no_idle <= 1'b0;
      kind = $urandom_range(0, 1) ? REQ_TRANSLATE : REQ_MAP;
      put_request(kind, pick_addr(), pick_frame());
    end

    wait_drained();
    repeat (16) @(posedge clk);
    $display("Sent %0d requests: %0d maps and %0d translates, after the store clear.",
             maps_sent + xlats_sent, maps_sent, xlats_sent);
    $display("Results: %0d ok, %0d page faults, %0d maps out of tables.",
             ok_seen, fault_seen, full_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/ptw_pkg.sv
src/ptw_ram.sv
src/ptw_ctrl.sv
src/ptw_dpath.sv
src/page_table_walker_core.sv
sim/page_walk_monitor.sv
sim/page_table_walker_core_test.sv
